/* src/nv_record_address_resolver_defines.svh */
// Assertion macros shared by the checker files of the record address resolver.
`ifndef NV_RECORD_ADDRESS_RESOLVER_DEFINES_SVH
`define NV_RECORD_ADDRESS_RESOLVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NVRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define NVRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/nvra_pkg.sv */
// Shared types and constants of the record address resolver.
`default_nettype none

package nvra_pkg;

	// Table geometry and field widths.
	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = 5;
	localparam int HALF_W      = 16;
	localparam int ADDR_W      = 32;
	localparam int REQ_W       = 2;
	localparam int REG_IDX_W   = 1;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd2;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_BASE_ADDRESS = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_ITEM_COUNT   = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_TOO_LONG  = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load;
		logic             capture;
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic             mul_en;
		logic             sel_rnum;
		logic             acc_en;
		logic             res_load;
		status_t          res_status;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic             hit;
		logic             too_long;
		logic [CNT_W-1:0] limit;
	} stat_t;

endpackage

`default_nettype wire

/* src/nvra_dp.sv */
// Datapath: entry table, request registers, offset accumulator and result registers.
`default_nettype none

module nvra_dp (
	input  wire                          clk,
	input  wire                          arst_n,
	input  nvra_pkg::cmd_t               cmd,
	output nvra_pkg::stat_t              stat,
	input  wire                          cfg_we,
	input  wire [nvra_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire [nvra_pkg::ADDR_W-1:0]   cfg_wdata,
	input  wire [nvra_pkg::REQ_W-1:0]    req_type,
	input  wire [nvra_pkg::IDX_W-1:0]    entry_index,
	input  wire [nvra_pkg::HALF_W-1:0]   item_id,
	input  wire [nvra_pkg::HALF_W-1:0]   record_size,
	input  wire [nvra_pkg::HALF_W-1:0]   record_count,
	input  wire [nvra_pkg::HALF_W-1:0]   record_number,
	input  wire [nvra_pkg::HALF_W-1:0]   length,
	output logic [nvra_pkg::ADDR_W-1:0]  flash_address,
	output logic [nvra_pkg::HALF_W-1:0]  transfer_length,
	output logic                         is_write,
	output logic [1:0]                   status
);

	localparam int ENTRY_W = 3 * nvra_pkg::HALF_W;

	logic [ENTRY_W-1:0]              entry_mem_q [nvra_pkg::MAX_ENTRIES];
	logic [nvra_pkg::ADDR_W-1:0]     base_q;
	logic [nvra_pkg::CNT_W-1:0]      item_count_q;
	logic [nvra_pkg::HALF_W-1:0]     req_id_q;
	logic [nvra_pkg::HALF_W-1:0]     req_rnum_q;
	logic [nvra_pkg::HALF_W-1:0]     req_len_q;
	logic                            req_write_q;
	logic [nvra_pkg::HALF_W-1:0]     rd_ident_s1;
	logic [nvra_pkg::HALF_W-1:0]     rd_size_s1;
	logic [nvra_pkg::HALF_W-1:0]     rd_count_s1;
	logic [nvra_pkg::ADDR_W-1:0]     prod_s2;
	logic [nvra_pkg::ADDR_W-1:0]     offset_q;
	logic [nvra_pkg::ADDR_W-1:0]     addr_q;
	logic [1:0]                      status_q;
	logic [nvra_pkg::HALF_W-1:0]     mul_rhs;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			item_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nvra_pkg::REG_BASE_ADDRESS: base_q <= cfg_wdata;
				nvra_pkg::REG_ITEM_COUNT:   item_count_q <= cfg_wdata[nvra_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Entry table: written by load transactions, read one entry a cycle during a scan.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			entry_mem_q[entry_index] <= {item_id, record_size, record_count};
		end
		if (cmd.rd_en) begin
			{rd_ident_s1, rd_size_s1, rd_count_s1} <= entry_mem_q[cmd.rd_idx];
		end
	end

	// Request fields are held for the whole scan.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_id_q    <= item_id;
			req_rnum_q  <= record_number;
			req_len_q   <= length;
			req_write_q <= (req_type == nvra_pkg::REQ_WRITE);
		end
	end

	// Size times count for earlier entries, size times record number at the match.
	assign mul_rhs = cmd.sel_rnum ? req_rnum_q : rd_count_s1;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s2 <= rd_size_s1 * mul_rhs;
		end
	end

	// Offset accumulator, wrapping at 32 bits.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			offset_q <= '0;
		end else if (cmd.acc_en) begin
			offset_q <= offset_q + prod_s2;
		end
	end

	// Result registers; the address reads zero on any error.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q <= cmd.res_status;
			addr_q   <= (cmd.res_status == nvra_pkg::ST_OK) ? base_q + offset_q : '0;
		end
	end

	// Status toward the controller.
	always_comb begin
		stat.hit      = (rd_ident_s1 == req_id_q);
		stat.too_long = (req_len_q > rd_size_s1);
		stat.limit    = (item_count_q > nvra_pkg::CNT_W'(nvra_pkg::MAX_ENTRIES))
			? nvra_pkg::CNT_W'(nvra_pkg::MAX_ENTRIES) : item_count_q;
	end

	assign flash_address   = addr_q;
	assign transfer_length = req_len_q;
	assign is_write        = req_write_q;
	assign status          = status_q;

endmodule

`default_nettype wire

/* src/nvra_ctrl.sv */
// Controller: accepts transactions and sequences the table scan.
`default_nettype none

module nvra_ctrl (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire [nvra_pkg::REQ_W-1:0]   req_type,
	input  nvra_pkg::stat_t             stat,
	output nvra_pkg::cmd_t              cmd,
	output logic                        busy,
	output logic                        done
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_MATCH = 5'b00100,
		S_ADDR  = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t                     state_q;
	state_t                     state_d;
	logic [nvra_pkg::CNT_W-1:0] idx_q;
	logic                       rd_v_s1;
	logic                       acc_v_s2;
	logic                       accept;

	assign accept = start && (state_q == S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.res_status = nvra_pkg::ST_OK;
		cmd.rd_idx     = idx_q[nvra_pkg::IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_type == nvra_pkg::REQ_LOAD) begin
						cmd.load = 1'b1;
					end else if (req_type == nvra_pkg::REQ_READ ||
						req_type == nvra_pkg::REQ_WRITE) begin
						cmd.capture = 1'b1;
						state_d     = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.acc_en = acc_v_s2;
				if (rd_v_s1 && stat.hit) begin
					if (stat.too_long) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = nvra_pkg::ST_TOO_LONG;
						state_d        = S_RESP;
					end else begin
						cmd.mul_en   = 1'b1;
						cmd.sel_rnum = 1'b1;
						state_d      = S_MATCH;
					end
				end else begin
					cmd.mul_en = rd_v_s1;
					if (idx_q < stat.limit) begin
						cmd.rd_en = 1'b1;
					end else if (!rd_v_s1) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = nvra_pkg::ST_NOT_FOUND;
						state_d        = S_RESP;
					end
				end
			end
			S_MATCH: begin
				cmd.acc_en = 1'b1;
				state_d    = S_ADDR;
			end
			S_ADDR: begin
				cmd.res_load = 1'b1;
				state_d      = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, scan index and pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			rd_v_s1  <= 1'b0;
			acc_v_s2 <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_v_s1  <= cmd.rd_en;
			acc_v_s2 <= cmd.mul_en;
			if (cmd.capture) begin
				idx_q <= '0;
			end else if (cmd.rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule

`default_nettype wire

/* src/nv_record_address_resolver.sv */
// Top level of the record address resolver: controller plus datapath.
//
// Usage: a transaction is taken at a rising edge where start is high and busy
// is low. A load transaction (req_type 0) writes table slot entry_index in
// that edge and leaves busy low, so loads may follow every cycle. Code 3 is
// dropped. A read or write request raises busy, walks the table entries in
// use from slot 0, one entry issued per cycle through the table read port,
// and ends with one result cycle where done is high and flash_address,
// transfer_length, is_write and status hold the answer.
// The scan stops at the first matching entry. A new transaction can be taken
// in the cycle after done.
// Configuration: cfg_we with cfg_index 0 writes base_address, index 1 writes
// item_count; write only while busy is low.
// Reset clears the controller, base_address and item_count; table contents
// are undefined until loaded. The receiver cannot stall: done lasts one cycle.
`default_nettype none

module nv_record_address_resolver (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	output logic                          busy,
	input  wire [nvra_pkg::REQ_W-1:0]     req_type,
	input  wire [nvra_pkg::IDX_W-1:0]     entry_index,
	input  wire [nvra_pkg::HALF_W-1:0]    item_id,
	input  wire [nvra_pkg::HALF_W-1:0]    record_size,
	input  wire [nvra_pkg::HALF_W-1:0]    record_count,
	input  wire [nvra_pkg::HALF_W-1:0]    record_number,
	input  wire [nvra_pkg::HALF_W-1:0]    length,
	input  wire                           cfg_we,
	input  wire [nvra_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire [nvra_pkg::ADDR_W-1:0]    cfg_wdata,
	output logic                          done,
	output logic [nvra_pkg::ADDR_W-1:0]   flash_address,
	output logic [nvra_pkg::HALF_W-1:0]   transfer_length,
	output logic                          is_write,
	output logic [1:0]                    status
);

	nvra_pkg::cmd_t  cmd;
	nvra_pkg::stat_t stat;

	// Transaction sequencing.
	nvra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	// Table, arithmetic and result registers.
	nvra_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.req_type        (req_type),
		.entry_index     (entry_index),
		.item_id         (item_id),
		.record_size     (record_size),
		.record_count    (record_count),
		.record_number   (record_number),
		.length          (length),
		.flash_address   (flash_address),
		.transfer_length (transfer_length),
		.is_write        (is_write),
		.status          (status)
	);

endmodule

`default_nettype wire

/* src/nvra_checker.sv */
// Port-level checker for the record address resolver, bound to the top level.
`default_nettype none
`include "nv_record_address_resolver_defines.svh"

module nvra_checker (
	input wire                       clk,
	input wire                       arst_n,
	input wire                       start,
	input wire                       busy,
	input wire [nvra_pkg::REQ_W-1:0] req_type,
	input wire                       done,
	input wire [1:0]                 status,
	input wire [nvra_pkg::ADDR_W-1:0] flash_address
);

	// A result only appears while a request is in progress.
	`NVRA_ASSERT_IMP(a_done_busy, clk, arst_n, done, busy, "result outside a request")

	// The result strobe lasts exactly one cycle.
	`NVRA_ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done, "result strobe longer than one cycle")

	// An accepted read or write request starts a scan.
	`NVRA_ASSERT_NXT(a_req_busy, clk, arst_n,
		start && !busy && (req_type == nvra_pkg::REQ_READ || req_type == nvra_pkg::REQ_WRITE),
		busy && !done, "request did not start a scan")

	// A failed request reports address zero.
	`NVRA_ASSERT_IMP(a_err_addr, clk, arst_n, done && (status != nvra_pkg::ST_OK),
		flash_address == '0, "nonzero address on an error result")

endmodule

bind nv_record_address_resolver nvra_checker u_nvra_checker (.*);

`default_nettype wire

/* bench/tb_nv_record_address_resolver.sv */
// Self-checking testbench for the record address resolver: queued stimulus, predictor, checker.
module tb_nv_record_address_resolver;
	import nvra_pkg::*;

	localparam int     SETTLE_CYCLES = 24;
	localparam int     MAX_GAP       = 12;
	localparam int     RANDOM_PHASES = 8;
	localparam int     PHASE_ITEMS   = 250;
	localparam longint WATCHDOG_TU   = 64'd10_000_000;

	// The request code that the block drops without a result.
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		OP_XACT,
		OP_CFG,
		OP_DRAIN
	} op_kind_t;

	// One entry of the stimulus backlog: a transaction, a register write or a drain.
	typedef struct {
		op_kind_t              kind;
		logic [REG_IDX_W-1:0]  reg_idx;
		logic [ADDR_W-1:0]     wdata;
		logic [REQ_W-1:0]      req;
		logic [IDX_W-1:0]      slot;
		logic [HALF_W-1:0]     id;
		logic [HALF_W-1:0]     rsize;
		logic [HALF_W-1:0]     rcount;
		logic [HALF_W-1:0]     rnum;
		logic [HALF_W-1:0]     len;
	} resolver_op_t;

	// One resolved address as the block should report it.
	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [HALF_W-1:0] len;
		logic              is_wr;
		status_t           st;
	} resolution_t;

	logic                 clk             = 1'b0;
	logic                 arst_n          = 1'b0;
	logic                 start           = 1'b0;
	logic [REQ_W-1:0]     req_type        = '0;
	logic [IDX_W-1:0]     entry_index     = '0;
	logic [HALF_W-1:0]    item_id         = '0;
	logic [HALF_W-1:0]    record_size     = '0;
	logic [HALF_W-1:0]    record_count    = '0;
	logic [HALF_W-1:0]    record_number   = '0;
	logic [HALF_W-1:0]    length          = '0;
	logic                 cfg_we          = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index       = '0;
	logic [ADDR_W-1:0]    cfg_wdata       = '0;
	logic                 busy;
	logic                 done;
	logic [ADDR_W-1:0]    flash_address;
	logic [HALF_W-1:0]    transfer_length;
	logic                 is_write;
	logic [1:0]           status;

	// Stimulus backlog and the answers still owed by the block.
	resolver_op_t op_backlog[$];
	resolution_t  awaited_answers[$];
	int           mismatch_count = 0;

	// Predictor copy of the item table and registers.
	logic [HALF_W-1:0] tbl_ident[MAX_ENTRIES];
	logic [HALF_W-1:0] tbl_size[MAX_ENTRIES];
	logic [HALF_W-1:0] tbl_count[MAX_ENTRIES];
	logic [ADDR_W-1:0] model_base  = '0;
	logic [CNT_W-1:0]  model_count = '0;

	// What the stimulus generator knows of the table, to aim requests at real items.
	logic [HALF_W-1:0] gen_ident[MAX_ENTRIES];
	logic [HALF_W-1:0] gen_size[MAX_ENTRIES];
	int unsigned       gen_lim = 0;

	// Driver bookkeeping.
	resolver_op_t cur_op;
	int           gap_left     = 0;
	int           calm_left    = 0;
	int           quiet_cycles = 0;

	nv_record_address_resolver uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.req_type        (req_type),
		.entry_index     (entry_index),
		.item_id         (item_id),
		.record_size     (record_size),
		.record_count    (record_count),
		.record_number   (record_number),
		.length          (length),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.done            (done),
		.flash_address   (flash_address),
		.transfer_length (transfer_length),
		.is_write        (is_write),
		.status          (status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one accepted transaction to the table copy and queue its answer, if any.
	function automatic void predict_resolution(input resolver_op_t op);
		int unsigned       lim;
		int unsigned       i;
		logic [ADDR_W-1:0] offset;
		resolution_t       ans;
		if (op.req == REQ_LOAD) begin
			tbl_ident[op.slot] = op.id;
			tbl_size[op.slot]  = op.rsize;
			tbl_count[op.slot] = op.rcount;
			return;
		end
		if (op.req != REQ_READ && op.req != REQ_WRITE)
			return;
		lim = (model_count > MAX_ENTRIES) ? MAX_ENTRIES : model_count;
		offset    = '0;
		ans.addr  = '0;
		ans.len   = op.len;
		ans.is_wr = (op.req == REQ_WRITE);
		ans.st    = ST_NOT_FOUND;
		// Earlier entries add their whole area; the first match adds its record offset.
		for (i = 0; i < lim && ans.st == ST_NOT_FOUND; i++) begin
			if (tbl_ident[i] == op.id) begin
				if (op.len > tbl_size[i]) begin
					ans.st = ST_TOO_LONG;
				end else begin
					ans.st   = ST_OK;
					offset   = offset + ADDR_W'(tbl_size[i]) * ADDR_W'(op.rnum);
					ans.addr = model_base + offset;
				end
			end else begin
				offset = offset + ADDR_W'(tbl_size[i]) * ADDR_W'(tbl_count[i]);
			end
		end
		awaited_answers.push_back(ans);
	endfunction

	// Queue one transaction for the driver.
	function automatic void queue_xact(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] slot,
			input logic [HALF_W-1:0] id, input logic [HALF_W-1:0] rsize,
			input logic [HALF_W-1:0] rcount, input logic [HALF_W-1:0] rnum,
			input logic [HALF_W-1:0] len);
		resolver_op_t op;
		op.kind    = OP_XACT;
		op.reg_idx = REG_BASE_ADDRESS;
		op.wdata   = '0;
		op.req     = req;
		op.slot    = slot;
		op.id      = id;
		op.rsize   = rsize;
		op.rcount  = rcount;
		op.rnum    = rnum;
		op.len     = len;
		if (req == REQ_LOAD) begin
			gen_ident[slot] = id;
			gen_size[slot]  = rsize;
		end
		op_backlog.push_back(op);
	endfunction

	// Queue a register write or a plain drain; both wait for the block to go quiet.
	function automatic void queue_control(input op_kind_t kind, input logic [REG_IDX_W-1:0] idx,
			input logic [ADDR_W-1:0] data);
		resolver_op_t op;
		op.kind    = kind;
		op.reg_idx = idx;
		op.wdata   = data;
		op.req     = REQ_UNUSED;
		op.slot    = '0;
		op.id      = '0;
		op.rsize   = '0;
		op.rcount  = '0;
		op.rnum    = '0;
		op.len     = '0;
		if (kind == OP_CFG && idx == REG_ITEM_COUNT)
			gen_lim = (data > MAX_ENTRIES) ? MAX_ENTRIES : data;
		op_backlog.push_back(op);
	endfunction

	// Driver: presents queued transactions with random gaps and performs register writes.
	always @(posedge clk) begin : drive_proc
		logic         nxt_start;
		logic         nxt_we;
		resolver_op_t op;
		if (!arst_n) begin
			start  <= 1'b0;
			cfg_we <= 1'b0;
		end else begin
			nxt_start = start;
			nxt_we    = 1'b0;
			if (start && !busy) begin
				predict_resolution(cur_op);
				nxt_start = 1'b0;
				// Draw the idle time before the next transaction; sometimes run without gaps.
				if (calm_left > 0) begin
					calm_left--;
					gap_left = 0;
				end else if ($urandom_range(0, 29) == 0) begin
					calm_left = $urandom_range(10, 40);
					gap_left  = 0;
				end else begin
					gap_left = $urandom_range(0, MAX_GAP);
				end
			end
			if (!start && !busy && awaited_answers.size() == 0)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			if (!nxt_start && op_backlog.size() > 0) begin
				op = op_backlog[0];
				if (op.kind != OP_XACT) begin
					// Register writes and drains go only once the block has settled.
					if (quiet_cycles >= SETTLE_CYCLES) begin
						void'(op_backlog.pop_front());
						quiet_cycles = 0;
						if (op.kind == OP_CFG) begin
							nxt_we = 1'b1;
							cfg_index <= op.reg_idx;
							cfg_wdata <= op.wdata;
							if (op.reg_idx == REG_BASE_ADDRESS)
								model_base = op.wdata;
							else
								model_count = op.wdata[CNT_W-1:0];
						end
					end
				end else if (gap_left > 0) begin
					gap_left--;
				end else begin
					cur_op = op_backlog.pop_front();
					nxt_start = 1'b1;
					req_type      <= op.req;
					entry_index   <= op.slot;
					item_id       <= op.id;
					record_size   <= op.rsize;
					record_count  <= op.rcount;
					record_number <= op.rnum;
					length        <= op.len;
				end
			end
			start  <= nxt_start;
			cfg_we <= nxt_we;
		end
	end

	// Monitor: every result strobe is matched against the oldest owed answer.
	always @(posedge clk) begin : check_proc
		resolution_t want;
		if (arst_n && done) begin
			if (awaited_answers.size() == 0) begin
				$error("result with none owed: flash_address=%h status=%0d",
					flash_address, status);
				mismatch_count++;
			end else begin
				want = awaited_answers.pop_front();
				if (flash_address !== want.addr) begin
					$error("flash_address: expected %h, actual %h", want.addr, flash_address);
					mismatch_count++;
				end
				if (transfer_length !== want.len) begin
					$error("transfer_length: expected %h, actual %h", want.len, transfer_length);
					mismatch_count++;
				end
				if (is_write !== want.is_wr) begin
					$error("is_write: expected %b, actual %b", want.is_wr, is_write);
					mismatch_count++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, actual %0d", want.st, status);
					mismatch_count++;
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin : stimulus_proc
		int unsigned       ph;
		int unsigned       n;
		int unsigned       sel;
		int unsigned       pick;
		int unsigned       slot;
		logic [HALF_W-1:0] id;
		logic [HALF_W-1:0] sz;
		logic [HALF_W-1:0] cnt;
		logic [HALF_W-1:0] rnum;
		logic [HALF_W-1:0] len;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] items;

		// Fill every slot before any request, so no scan ever meets an unloaded entry.
		// Slots 0 and 1 together span exactly an all-ones offset; slot 4 repeats slot 2's id.
		queue_xact(REQ_LOAD, 4'd0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
		queue_xact(REQ_LOAD, 4'd1, 16'hFFFF, 16'h0002, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_xact(REQ_LOAD, 4'd2, 16'h1234, 16'h0010, 16'h0004, 16'h0000, 16'h0000);
		queue_xact(REQ_LOAD, 4'd3, 16'hA5A5, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		queue_xact(REQ_LOAD, 4'd4, 16'h1234, 16'h0020, 16'h0002, 16'h0000, 16'h0000);
		for (n = 5; n < MAX_ENTRIES; n++)
			queue_xact(REQ_LOAD, IDX_W'(n), 16'h5A00 | HALF_W'(n), 16'h0040 + HALF_W'(n),
				HALF_W'(n + 1), 16'h0000, 16'h0000);

		// Directed requests: wrapping base, widest product, size zero, first of two matches.
		queue_control(OP_CFG, REG_BASE_ADDRESS, 32'hFFFF_FFF0);
		queue_control(OP_CFG, REG_ITEM_COUNT, 32'd16);
		queue_xact(REQ_READ, 4'hF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
		queue_xact(REQ_WRITE, 4'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0002);
		queue_xact(REQ_READ, 4'h0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 16'h0003);
		queue_xact(REQ_READ, 4'h0, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		queue_xact(REQ_WRITE, 4'h0, 16'hA5A5, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
		queue_xact(REQ_WRITE, 4'h0, 16'hA5A5, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
		queue_xact(REQ_READ, 4'h0, 16'hBEEF, 16'h0000, 16'h0000, 16'h0003, 16'h0001);
		queue_xact(REQ_UNUSED, 4'hF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_xact(REQ_WRITE, 4'h0, 16'h5A0F, 16'h0000, 16'h0000, 16'h0007, 16'h004F);
		// An item count above the table size scans only the table.
		queue_control(OP_CFG, REG_BASE_ADDRESS, 32'h0000_0000);
		queue_control(OP_CFG, REG_ITEM_COUNT, 32'd31);
		queue_xact(REQ_READ, 4'h0, 16'h5A0F, 16'h0000, 16'h0000, 16'h0000, 16'h0050);
		queue_xact(REQ_READ, 4'h0, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		// With no entries in use every identifier is unknown.
		queue_control(OP_CFG, REG_ITEM_COUNT, 32'd0);
		queue_xact(REQ_READ, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

		// Random phases, each under its own register setting.
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0:       base = 32'h0000_0000;
				1:       base = 32'hFFFF_FFFF;
				default: base = $urandom;
			endcase
			case (ph)
				0:       items = 32'd16;
				1:       items = 32'd31;
				2:       items = 32'd1;
				3:       items = 32'd0;
				4:       items = $urandom_range(2, 15);
				5:       items = 32'd16;
				6:       items = $urandom_range(0, 31);
				default: items = $urandom_range(8, 16);
			endcase
			queue_control(OP_CFG, REG_BASE_ADDRESS, base);
			queue_control(OP_CFG, REG_ITEM_COUNT, items);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// Halfway through, hold the sender until every owed answer is in.
				if (n == PHASE_ITEMS / 2)
					queue_control(OP_DRAIN, REG_BASE_ADDRESS, '0);
				sel  = $urandom_range(0, 99);
				slot = $urandom_range(0, MAX_ENTRIES - 1);
				rnum = $urandom_range(0, 1) ? HALF_W'($urandom_range(0, 16)) : HALF_W'($urandom);
				if (sel < 12) begin
					// Reload a slot; sometimes reuse another slot's identifier.
					id  = ($urandom_range(0, 3) == 0) ?
						gen_ident[$urandom_range(0, MAX_ENTRIES - 1)] : HALF_W'($urandom);
					sz  = $urandom_range(0, 1) ? HALF_W'($urandom_range(0, 64)) : HALF_W'($urandom);
					cnt = $urandom_range(0, 1) ? HALF_W'($urandom_range(0, 64)) : HALF_W'($urandom);
					queue_xact(REQ_LOAD, IDX_W'(slot), id, sz, cnt, rnum, HALF_W'($urandom));
				end else if (sel < 15) begin
					queue_xact(REQ_UNUSED, IDX_W'(slot), HALF_W'($urandom), HALF_W'($urandom),
						HALF_W'($urandom), rnum, HALF_W'($urandom));
				end else begin
					// Mostly requests for an item in use, with a length that fits or is too long.
					if (sel < 85 && gen_lim > 0) begin
						slot = $urandom_range(0, gen_lim - 1);
						id   = gen_ident[slot];
						sz   = gen_size[slot];
						pick = $urandom_range(0, 9);
						if (pick < 7)
							len = HALF_W'($urandom_range(0, sz));
						else if (pick < 9 && sz != 16'hFFFF)
							len = HALF_W'($urandom_range(sz + 1, 16'hFFFF));
						else
							len = HALF_W'($urandom);
					end else begin
						id  = HALF_W'($urandom);
						len = HALF_W'($urandom);
					end
					queue_xact($urandom_range(0, 1) ? REQ_WRITE : REQ_READ,
						IDX_W'($urandom_range(0, MAX_ENTRIES - 1)), id, HALF_W'($urandom),
						HALF_W'($urandom), rnum, len);
				end
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (op_backlog.size() != 0 || start || busy || awaited_answers.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin : watchdog_proc
		#(WATCHDOG_TU);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
